>>> src/two_stage_table_interpolator_core_macros.svh
// Assertion macros shared by the checker of the two-stage table interpolator.
`ifndef TWO_STAGE_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define TWO_STAGE_TABLE_INTERPOLATOR_CORE_MACROS_SVH

// Antecedent in one cycle implies the consequent in the next, checked outside reset.
`define TSTI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interpolator check failed");

// Antecedent implies the consequent in the same cycle, checked outside reset.
`define TSTI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interpolator check failed");

// Checked at every edge, reset included.
`define TSTI_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("interpolator check failed");

`endif

>>> src/tsti_pkg.sv
// Shared types and constants of the two-stage table interpolator.
package tsti_pkg;

   // Default table sizes and fixed field widths.
   localparam int IMP_POINTS_DEF = 32;
   localparam int DAC_POINTS_DEF = 32;
   localparam int RAM_DEPTH_DEF  = 256;
   localparam int LEVELS         = 4;
   localparam int LEVEL_W        = 2;
   localparam int INDEX_W        = 6;
   localparam int WORD_W         = 16;

   // Percent scaling: factors stay below 100 and fit in seven bits.
   localparam int PCT        = 100;
   localparam int QUOT_W     = 7;
   localparam int DIVIDEND_W = WORD_W + QUOT_W;

   // Division by 100 as a multiplication by ceil(2^30 / 100), exact below 2^23.
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 24'd10737419;

   // Request kinds and table selection codes.
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;
   localparam logic TABLE_IMP  = 1'b0;
   localparam logic TABLE_DAC  = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic                 table_sel;
      logic [LEVEL_W-1:0]   level;
      logic [INDEX_W-1:0]   word_index;
      logic [WORD_W-1:0]    word_value;
      logic [WORD_W-1:0]    impedance;
   } req_beat_type;

   typedef struct packed {
      logic [WORD_W-1:0] corrected_impedance;
      logic [WORD_W-1:0] dac_value;
   } rsp_beat_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] active_level;
   } csr_beat_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_status_type;

endpackage

>>> src/tsti_if.sv
// Valid/ready channel interfaces for requests, responses and the level register.
interface tsti_req_if;
   logic                    valid;
   logic                    ready;
   tsti_pkg::req_beat_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tsti_rsp_if;
   logic                    valid;
   logic                    ready;
   tsti_pkg::rsp_beat_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tsti_csr_if;
   logic                    valid;
   logic                    ready;
   tsti_pkg::csr_beat_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/tsti_ram.sv
// Generic single-port synchronous RAM with a registered read.
module tsti_ram #(
   parameter int WIDTH = tsti_pkg::WORD_W,
   parameter int DEPTH = tsti_pkg::RAM_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, read the addressed word every cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/tsti_div.sv
// Bit-serial restoring divider for the percent factor, one quotient bit per cycle.
module tsti_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tsti_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [tsti_pkg::WORD_W-1:0]     divisor,
   output tsti_pkg::div_status_type        status
);

   localparam int DW    = tsti_pkg::DIVIDEND_W;
   localparam int QW    = tsti_pkg::QUOT_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [DW-1:0]    rem_ff,  rem_in;
   logic [DW-1:0]    dsh_ff,  dsh_in;
   logic [QW-1:0]    quo_ff,  quo_in;

   // The quotient is known to fit in QW bits, so the divisor starts shifted by QW-1.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QW);
         rem_in  = dividend;
         dsh_in  = DW'(divisor) << (QW - 1);
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   // The quotient is complete once every step has run.
   assign status.done     = busy_ff && (cnt_ff == '0);
   assign status.quotient = quo_ff;

endmodule

>>> src/two_stage_table_interpolator_core.sv
// Two-stage calibration table interpolator: four impedance/DAC table pairs, one per power
// level, each table N ascending breakpoints followed by N values, held in two single-port
// RAMs. A write beat stores one table word and leaves the engine idle. A lookup beat bisects
// the active level's impedance table, interpolates with a truncated percent factor, then
// does the same with that result in the DAC table. Each bisection step passes through a
// probe state and a compare state for the RAM's registered read; once the search ends, the
// two bracketing breakpoints and values are fetched, the bit-serial divider runs, and the
// result is scaled and handed on. At the top of a table the value is clamped and the
// divider is skipped. New request beats are taken only while the engine is idle, but a
// finished result waits in the output register without blocking the next beat. Table
// contents are undefined until written; there is no clearing pass after reset.
module two_stage_table_interpolator_core #(
   parameter int IMP_POINTS = tsti_pkg::IMP_POINTS_DEF,
   parameter int DAC_POINTS = tsti_pkg::DAC_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tsti_req_if.sink    req_if,
   tsti_rsp_if.source  rsp_if,
   tsti_csr_if.sink    csr_if
);

   localparam int WORD_W    = tsti_pkg::WORD_W;
   localparam int LEVEL_W   = tsti_pkg::LEVEL_W;
   localparam int DW        = tsti_pkg::DIVIDEND_W;
   localparam int RW        = tsti_pkg::DIVIDEND_W + tsti_pkg::RECIP_W;
   localparam int NMAX      = (IMP_POINTS > DAC_POINTS) ? IMP_POINTS : DAC_POINTS;
   localparam int CW        = $clog2(NMAX + 1);
   localparam int WW        = $clog2(2 * NMAX);
   localparam int IMP_AW    = $clog2(2 * IMP_POINTS);
   localparam int DAC_AW    = $clog2(2 * DAC_POINTS);
   localparam int IMP_DEPTH = tsti_pkg::LEVELS << IMP_AW;
   localparam int DAC_DEPTH = tsti_pkg::LEVELS << DAC_AW;
   localparam int CMP_W     = WW + tsti_pkg::INDEX_W + 1;
   localparam logic [WW:0] ONE_W      = (WW+1)'(1);
   localparam logic [2:0]  FETCH_LAST = 3'd4;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_SRCH   = 9'b000000010,
      S_CMP    = 9'b000000100,
      S_FETCH  = 9'b000001000,
      S_DIV    = 9'b000010000,
      S_RECIP  = 9'b000100000,
      S_FINISH = 9'b001000000,
      S_NEXT   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   logic                   stage_ff, stage_in;
   logic [WORD_W-1:0]      x_ff, x_in;
   logic [CW-1:0]          lo_ff, lo_in;
   logic [CW-1:0]          hi_ff, hi_in;
   logic [CW-1:0]          p_ff, p_in;
   logic [2:0]             fc_ff, fc_in;
   logic [WORD_W-1:0]      bp_ff, bp_in;
   logic [WORD_W-1:0]      bn_ff, bn_in;
   logic [WORD_W-1:0]      vp_ff, vp_in;
   logic [WORD_W-1:0]      vn_ff, vn_in;
   logic                   below_ff, below_in;
   logic                   neg_ff, neg_in;
   logic [DW-1:0]          prod_ff, prod_in;
   logic [RW-1:0]          recip_ff, recip_in;
   logic [WORD_W-1:0]      res_ff, res_in;
   logic [WORD_W-1:0]      corr_ff, corr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tsti_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;
   logic [LEVEL_W-1:0]     csr_level_ff, csr_level_in;

   logic                   req_acc;
   logic                   lookup_acc;
   logic                   write_acc;
   logic [CW-1:0]          n_cur;
   logic [CW-1:0]          span;
   logic [CW:0]            p_sum;
   logic [CW-1:0]          p_cur;
   logic [WW:0]            rd_word_wide;
   logic [WW-1:0]          rd_word;
   logic [WORD_W-1:0]      imp_rdata;
   logic [WORD_W-1:0]      dac_rdata;
   logic [WORD_W-1:0]      rd_data;
   logic                   imp_we;
   logic                   dac_we;
   logic [LEVEL_W+IMP_AW-1:0] imp_addr;
   logic [LEVEL_W+DAC_AW-1:0] dac_addr;
   logic                   below_now;
   logic                   div_start;
   logic [DW-1:0]          dividend;
   logic [WORD_W-1:0]      divisor;
   tsti_pkg::div_status_type div_status;
   logic [WORD_W:0]        diff_v;
   logic [WORD_W-1:0]      dabs;
   logic [WORD_W-1:0]      factor;
   logic [WORD_W-1:0]      q;

   // Handshakes: request beats are taken only while the engine is idle; level beats are always taken.
   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_acc      = req_if.valid && req_if.ready;
   assign lookup_acc   = req_acc && (req_if.data.req_type == tsti_pkg::REQ_LOOKUP);
   assign write_acc    = req_acc && (req_if.data.req_type == tsti_pkg::REQ_WRITE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // Bisection bounds of the table being searched.
   assign n_cur = (stage_ff == tsti_pkg::TABLE_DAC) ? CW'(DAC_POINTS) : CW'(IMP_POINTS);
   assign span  = hi_ff - lo_ff;
   assign p_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign p_cur = p_sum[CW:1];

   // Word of the table read this cycle: the probe during the search, then the bracket.
   always_comb begin
      rd_word_wide = (WW+1)'(p_cur);
      if (state_ff == S_FETCH) begin
         case (fc_ff)
            3'd0:    rd_word_wide = (WW+1)'(hi_ff) - ONE_W;
            3'd1:    rd_word_wide = (WW+1)'(hi_ff);
            3'd2:    rd_word_wide = (WW+1)'(n_cur) + (WW+1)'(hi_ff) - ONE_W;
            default: rd_word_wide = (WW+1)'(n_cur) + (WW+1)'(hi_ff);
         endcase
      end
   end
   assign rd_word = rd_word_wide[WW-1:0];

   // Table memories: written from write beats while idle, read by the engine otherwise.
   assign imp_we = write_acc && (req_if.data.table_sel == tsti_pkg::TABLE_IMP) &&
                   (CMP_W'(req_if.data.word_index) < CMP_W'(2 * IMP_POINTS));
   assign dac_we = write_acc && (req_if.data.table_sel == tsti_pkg::TABLE_DAC) &&
                   (CMP_W'(req_if.data.word_index) < CMP_W'(2 * DAC_POINTS));
   assign imp_addr = (state_ff == S_IDLE) ?
                     {req_if.data.level, IMP_AW'(req_if.data.word_index)} :
                     {csr_level_ff, rd_word[IMP_AW-1:0]};
   assign dac_addr = (state_ff == S_IDLE) ?
                     {req_if.data.level, DAC_AW'(req_if.data.word_index)} :
                     {csr_level_ff, rd_word[DAC_AW-1:0]};

   tsti_ram #(.WIDTH(WORD_W), .DEPTH(IMP_DEPTH)) u_imp_ram (
      .clock (clock),
      .we    (imp_we),
      .addr  (imp_addr),
      .wdata (req_if.data.word_value),
      .rdata (imp_rdata)
   );

   tsti_ram #(.WIDTH(WORD_W), .DEPTH(DAC_DEPTH)) u_dac_ram (
      .clock (clock),
      .we    (dac_we),
      .addr  (dac_addr),
      .wdata (req_if.data.word_value),
      .rdata (dac_rdata)
   );

   assign rd_data = (stage_ff == tsti_pkg::TABLE_DAC) ? dac_rdata : imp_rdata;

   // Percent factor operands: scaled from zero below the first breakpoint.
   assign below_now = x_ff < bp_ff;
   assign dividend  = below_now ? DW'(x_ff) * DW'(tsti_pkg::PCT)
                                : DW'(x_ff - bp_ff) * DW'(tsti_pkg::PCT);
   assign divisor   = below_now ? bp_ff : bn_ff - bp_ff;

   tsti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .status   (div_status)
   );

   // Value step between breakpoints as sign and magnitude, so that the division by
   // 100 truncates towards zero.
   assign diff_v = {1'b0, vn_ff} - {1'b0, vp_ff};
   assign dabs   = diff_v[WORD_W] ? WORD_W'(-diff_v) : diff_v[WORD_W-1:0];
   assign factor = below_ff ? vp_ff : dabs;
   assign q      = recip_ff[tsti_pkg::RECIP_SHIFT +: WORD_W];

   // Lookup sequencer.
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      x_in         = x_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      p_in         = p_ff;
      fc_in        = fc_ff;
      bp_in        = bp_ff;
      bn_in        = bn_ff;
      vp_in        = vp_ff;
      vn_in        = vn_ff;
      below_in     = below_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      recip_in     = recip_ff;
      res_in       = res_ff;
      corr_in      = corr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      div_start    = 1'b0;
      csr_level_in = csr_if.valid ? csr_if.data.active_level : csr_level_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (lookup_acc) begin
               x_in     = req_if.data.impedance;
               stage_in = tsti_pkg::TABLE_IMP;
               lo_in    = '0;
               hi_in    = CW'(IMP_POINTS);
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (span > CW'(1)) begin
               p_in     = p_cur;
               state_in = S_CMP;
            end else begin
               fc_in    = '0;
               state_in = S_FETCH;
            end
         end
         S_CMP: begin
            if (rd_data > x_ff) begin
               hi_in = p_ff;
            end else begin
               lo_in = p_ff;
            end
            state_in = S_SRCH;
         end
         S_FETCH: begin
            // Reads go out on counts 0 to 3 and are captured on counts 1 to 4.
            fc_in = fc_ff + 3'd1;
            case (fc_ff)
               3'd1:    bp_in = rd_data;
               3'd2:    bn_in = rd_data;
               3'd3:    vp_in = rd_data;
               3'd4:    vn_in = rd_data;
               default: bp_in = bp_ff;
            endcase
            if (fc_ff == FETCH_LAST) begin
               below_in = below_now;
               if (hi_ff == n_cur) begin
                  // At or above the last breakpoint: clamp to the last value.
                  res_in   = vp_ff;
                  state_in = S_NEXT;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               prod_in  = DW'(factor) * DW'(div_status.quotient);
               neg_in   = !below_ff && diff_v[WORD_W];
               state_in = S_RECIP;
            end
         end
         S_RECIP: begin
            recip_in = RW'(prod_ff) * RW'(tsti_pkg::RECIP_MULT);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (below_ff) begin
               res_in = q;
            end else if (neg_ff) begin
               res_in = vp_ff - q;
            end else begin
               res_in = vp_ff + q;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (stage_ff == tsti_pkg::TABLE_IMP) begin
               // Feed the corrected impedance into the DAC table.
               corr_in  = res_ff;
               x_in     = res_ff;
               stage_in = tsti_pkg::TABLE_DAC;
               lo_in    = '0;
               hi_in    = CW'(DAC_POINTS);
               state_in = S_SRCH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_data_in.corrected_impedance = corr_ff;
               rsp_data_in.dac_value           = res_ff;
               rsp_valid_in                    = 1'b1;
               state_in                        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         csr_level_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         csr_level_ff <= csr_level_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      x_ff        <= x_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      p_ff        <= p_in;
      fc_ff       <= fc_in;
      bp_ff       <= bp_in;
      bn_ff       <= bn_in;
      vp_ff       <= vp_in;
      vn_ff       <= vn_in;
      below_ff    <= below_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      recip_ff    <= recip_in;
      res_ff      <= res_in;
      corr_ff     <= corr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> src/tsti_checker.sv
// Port-level checks of the interpolator, bound to its top level.
`include "two_stage_table_interpolator_core_macros.svh"

module tsti_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_type,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input tsti_pkg::rsp_beat_type rsp_data
);

   // No result is offered straight after reset.
   `TSTI_ASSERT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid)

   // A stalled result beat holds its value.
   `TSTI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A lookup beat occupies the engine for the following cycle.
   `TSTI_ASSERT_NEXT(a_lookup_busy, clock, reset, req_valid && req_ready && req_type == tsti_pkg::REQ_LOOKUP, !req_ready)

   // A table write completes in the cycle it is taken.
   `TSTI_ASSERT_NEXT(a_write_single, clock, reset, req_valid && req_ready && req_type == tsti_pkg::REQ_WRITE, req_ready)

   // A new result only appears after the engine has been busy.
   `TSTI_ASSERT_NOW(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind two_stage_table_interpolator_core tsti_checker u_tsti_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_type  (req_if.data.req_type),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

>>> sim/tb_two_stage_table_interpolator_core.sv
// Self-checking testbench of the two-stage table interpolator core, with a table-based predictor.
module tb_two_stage_table_interpolator_core;

   localparam int IMP_N         = tsti_pkg::IMP_POINTS_DEF;
   localparam int DAC_N         = tsti_pkg::DAC_POINTS_DEF;
   localparam int WORD_W        = tsti_pkg::WORD_W;
   localparam int LEVEL_W       = tsti_pkg::LEVEL_W;
   localparam int INDEX_W       = tsti_pkg::INDEX_W;
   localparam int LEVELS        = tsti_pkg::LEVELS;
   localparam int PCT           = tsti_pkg::PCT;
   localparam int SETTLE_CYCLES = 120;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_TRIGGER  = 900;
   localparam int PHASE_ITEMS   = 145;
   localparam int PHASES        = 6;
   localparam int REPORT_LIMIT  = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic choke = 1'b0;

   tsti_req_if req_ch ();
   tsti_rsp_if rsp_ch ();
   tsti_csr_if csr_ch ();

   two_stage_table_interpolator_core #(
      .IMP_POINTS (IMP_N),
      .DAC_POINTS (DAC_N)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Predicted table contents, updated as write beats are accepted.
   logic [WORD_W-1:0]  imp_words [LEVELS][2*IMP_N];
   logic [WORD_W-1:0]  dac_words [LEVELS][2*DAC_N];
   logic [LEVEL_W-1:0] level_now = '0;

   // Table contents as the stimulus will leave them, used to aim lookups at breakpoints.
   logic [WORD_W-1:0]  plan_imp [LEVELS][2*IMP_N];
   logic [WORD_W-1:0]  plan_dac [LEVELS][2*DAC_N];

   logic [LEVEL_W-1:0] phase_levels [PHASES] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2};

   tsti_pkg::req_beat_type req_backlog [$];
   tsti_pkg::rsp_beat_type expected_results [$];
   int issued_beats   = 0;
   int accepted_beats = 0;
   int mismatch_count = 0;
   int req_gap  = 0;
   int req_calm = 0;
   int rsp_gap  = 0;
   int rsp_calm = 0;

   // Clock generation.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle cycles before the next beat, with occasional stretches of back-to-back beats.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         calm_left = 20;
      return $urandom_range(0, 4);
   endfunction

   function automatic int table_word(logic sel, logic [LEVEL_W-1:0] lvl, int k);
      if (sel == tsti_pkg::TABLE_DAC)
         return dac_words[lvl][k];
      return imp_words[lvl][k];
   endfunction

   // Bisect the breakpoints for the first one above x, then interpolate by a whole percent.
   function automatic logic [WORD_W-1:0] interpolate_word(logic sel, logic [LEVEL_W-1:0] lvl,
                                                          logic [WORD_W-1:0] x);
      int n, lo, hi, mid, xi, bp, f, base, d;
      n  = (sel == tsti_pkg::TABLE_DAC) ? DAC_N : IMP_N;
      xi = x;
      lo = 0;
      hi = n;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (table_word(sel, lvl, mid) > xi)
            hi = mid;
         else
            lo = mid;
      end
      // At or above the last breakpoint the output clamps to the last value.
      if (hi == n)
         return WORD_W'(table_word(sel, lvl, 2*n - 1));
      bp = table_word(sel, lvl, hi - 1);
      // Below the bracketing breakpoint the value is scaled from zero.
      if (xi < bp) begin
         f = (xi * PCT) / bp;
         return WORD_W'((table_word(sel, lvl, n + hi - 1) * f) / PCT);
      end
      // Between breakpoints; a falling segment truncates towards zero.
      f    = ((xi - bp) * PCT) / (table_word(sel, lvl, hi) - bp);
      base = table_word(sel, lvl, n + hi - 1);
      d    = table_word(sel, lvl, n + hi) - base;
      return WORD_W'(base + (d * f) / PCT);
   endfunction

   // Apply one accepted request beat to the predicted state.
   task automatic apply_request(tsti_pkg::req_beat_type r);
      tsti_pkg::rsp_beat_type e;
      if (r.req_type == tsti_pkg::REQ_WRITE) begin
         if (r.table_sel == tsti_pkg::TABLE_IMP) begin
            if (r.word_index < 2*IMP_N)
               imp_words[r.level][r.word_index] = r.word_value;
         end else begin
            if (r.word_index < 2*DAC_N)
               dac_words[r.level][r.word_index] = r.word_value;
         end
      end else begin
         e.corrected_impedance = interpolate_word(tsti_pkg::TABLE_IMP, level_now, r.impedance);
         e.dac_value           = interpolate_word(tsti_pkg::TABLE_DAC, level_now,
                                                  e.corrected_impedance);
         expected_results.push_back(e);
      end
   endtask

   function automatic void note_mismatch(string what, logic [WORD_W-1:0] want,
                                         logic [WORD_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
   endfunction

   // Request driver: presents queued beats and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_request(req_ch.data);
            accepted_beats++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_ch.valid <= 1'b0;
               req_gap--;
            end else if (req_backlog.size() != 0) begin
               req_ch.data  <= req_backlog.pop_front();
               req_ch.valid <= 1'b1;
               req_gap = draw_gap(req_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each beat against the oldest prediction and stalls at random.
   always @(posedge clock) begin
      tsti_pkg::rsp_beat_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_results.size() == 0) begin
               note_mismatch("response beat with no lookup outstanding", 'x,
                             got.corrected_impedance);
            end else begin
               want = expected_results.pop_front();
               if (got.corrected_impedance !== want.corrected_impedance)
                  note_mismatch("corrected_impedance", want.corrected_impedance,
                                got.corrected_impedance);
               if (got.dac_value !== want.dac_value)
                  note_mismatch("dac_value", want.dac_value, got.dac_value);
            end
            rsp_gap = draw_gap(rsp_calm);
         end
         if (rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ch.ready <= !choke;
         end
      end
   end

   // One long hold-off on the response side while requests keep coming, to back the block up.
   initial begin
      wait (accepted_beats >= HOLD_TRIGGER);
      @(posedge clock);
      choke <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      choke <= 1'b0;
   end

   task automatic queue_write(logic sel, logic [LEVEL_W-1:0] lvl, logic [INDEX_W-1:0] idx,
                              logic [WORD_W-1:0] val);
      tsti_pkg::req_beat_type r;
      r.req_type   = tsti_pkg::REQ_WRITE;
      r.table_sel  = sel;
      r.level      = lvl;
      r.word_index = idx;
      r.word_value = val;
      r.impedance  = WORD_W'($urandom);
      req_backlog.push_back(r);
      issued_beats++;
      if (sel == tsti_pkg::TABLE_DAC)
         plan_dac[lvl][idx] = val;
      else
         plan_imp[lvl][idx] = val;
   endtask

   // Lookup beats carry random junk in the write-only fields.
   task automatic queue_lookup(logic [WORD_W-1:0] imp);
      tsti_pkg::req_beat_type r;
      r.req_type   = tsti_pkg::REQ_LOOKUP;
      r.table_sel  = 1'($urandom);
      r.level      = LEVEL_W'($urandom);
      r.word_index = INDEX_W'($urandom);
      r.word_value = WORD_W'($urandom);
      r.impedance  = imp;
      req_backlog.push_back(r);
      issued_beats++;
   endtask

   // Fill one whole table. Level 0 rises, level 1 has falling values, level 2 is unsorted
   // noise, level 3 has paired equal breakpoints and values swinging between the extremes.
   task automatic load_table(logic sel, logic [LEVEL_W-1:0] lvl);
      int n, step, vstep, bp, val;
      n     = (sel == tsti_pkg::TABLE_DAC) ? DAC_N : IMP_N;
      step  = 60000 / n;
      vstep = 64000 / n;
      for (int k = 0; k < n; k++) begin
         case (lvl)
            2'd0: begin
               bp  = 800 + k*step + $urandom_range(0, step*3/4);
               val = k*vstep + $urandom_range(0, vstep - 1);
            end
            2'd1: begin
               bp  = 800 + k*step + $urandom_range(0, step*3/4);
               val = 65535 - (k*vstep + $urandom_range(0, vstep - 1));
            end
            2'd2: begin
               bp  = $urandom_range(0, 65535);
               val = $urandom_range(0, 65535);
            end
            default: begin
               bp  = (k == n - 1) ? 65535 : (k / 2) * step * 2;
               val = (k % 2 == 1) ? 65535 : 0;
            end
         endcase
         queue_write(sel, lvl, INDEX_W'(k), WORD_W'(bp));
         queue_write(sel, lvl, INDEX_W'(n + k), WORD_W'(val));
      end
   endtask

   // Block until every queued beat is taken and answered, then let the engine settle.
   task automatic wait_for_drain();
      while (accepted_beats < issued_beats || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_active_level(logic [LEVEL_W-1:0] lvl);
      tsti_pkg::csr_beat_type c;
      c.active_level = lvl;
      csr_ch.data  <= c;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
      level_now = lvl;
   endtask

   // Stimulus: load every table, probe the edges of level 0, then random phases per level.
   initial begin
      int probe [16];
      int pick;
      logic sel;
      logic [LEVEL_W-1:0] lvl;
      logic [INDEX_W-1:0] idx;
      logic [WORD_W-1:0]  old;
      logic [WORD_W-1:0]  val;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_active_level(2'd0);

      for (int l = 0; l < LEVELS; l++) begin
         load_table(tsti_pkg::TABLE_IMP, LEVEL_W'(l));
         load_table(tsti_pkg::TABLE_DAC, LEVEL_W'(l));
      end

      // Zero, below the first breakpoint, on and around breakpoints, the top, and full scale.
      probe = '{0, 1, plan_imp[0][0] - 1, plan_imp[0][0], plan_imp[0][0] + 1,
                plan_imp[0][1] - 1, plan_imp[0][1], (plan_imp[0][5] + plan_imp[0][6]) / 2,
                plan_imp[0][15], plan_imp[0][IMP_N-2], plan_imp[0][IMP_N-1] - 1,
                plan_imp[0][IMP_N-1], plan_imp[0][IMP_N-1] + 1, 16'h7FFF, 16'h8000, 16'hFFFF};
      foreach (probe[i])
         queue_lookup(WORD_W'(probe[i]));

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_for_drain();
         set_active_level(phase_levels[ph]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               // Rewrite a word, either at random or as a small nudge to keep the shape.
               sel = 1'($urandom);
               lvl = LEVEL_W'($urandom);
               idx = INDEX_W'($urandom);
               old = (sel == tsti_pkg::TABLE_DAC) ? plan_dac[lvl][idx] : plan_imp[lvl][idx];
               if ($urandom_range(0, 1) == 0)
                  val = WORD_W'($urandom);
               else
                  val = WORD_W'(old + $urandom_range(0, 64) - 32);
               queue_write(sel, lvl, idx, val);
            end else if (pick < 60) begin
               old = plan_imp[level_now][$urandom_range(0, IMP_N - 1)];
               queue_lookup(WORD_W'(old + $urandom_range(0, 4) - 2));
            end else begin
               queue_lookup(WORD_W'($urandom));
            end
         end
      end

      wait_for_drain();
      mismatch_count += expected_results.size();
      if (mismatch_count == 0)
         $display("two_stage_table_interpolator_core: match");
      else
         $display("two_stage_table_interpolator_core: mismatch");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10_000_000;
      $display("two_stage_table_interpolator_core: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/tsti_pkg.sv
src/tsti_if.sv
src/tsti_ram.sv
src/tsti_div.sv
src/two_stage_table_interpolator_core.sv
src/tsti_checker.sv
sim/tb_two_stage_table_interpolator_core.sv
